// File: hdl/tpcc_pkg.sv
// ----------------------------------------------------------------------------
// tpcc_pkg
// Shared types, constants and saturating helpers for the three-phase
// capacitor companion block.
// ----------------------------------------------------------------------------
package tpcc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int PHASES     = 3;

  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [0:0] {
    REQ_STEP = 1'b0,
    REQ_INIT = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    REG_COND_AA = 3'd0,
    REG_COND_BB = 3'd1,
    REG_COND_CC = 3'd2,
    REG_COND_AB = 3'd3,
    REG_COND_AC = 3'd4,
    REG_COND_BC = 3'd5,
    REG_TERM0_GND = 3'd6,
    REG_TERM1_GND = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic  req_type;
    data_t node0_a;
    data_t node0_b;
    data_t node0_c;
    data_t node1_a;
    data_t node1_b;
    data_t node1_c;
  } req_t;

  typedef struct packed {
    data_t volt_a;
    data_t volt_b;
    data_t volt_c;
    data_t curr_a;
    data_t curr_b;
    data_t curr_c;
    data_t hist_a;
    data_t hist_b;
    data_t hist_c;
  } rsp_t;

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? DMIN : DMAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? DMIN : DMAX;
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic data_t sat_neg(input data_t a);
    return (a == DMIN) ? DMAX : -a;
  endfunction

endpackage

// File: hdl/tpcc_fxmul.sv
// ----------------------------------------------------------------------------
// tpcc_fxmul
// Fixed point multiply: exact product, floor shift by the fraction bits,
// saturation to the data width.
// ----------------------------------------------------------------------------
module tpcc_fxmul
  import tpcc_pkg::*;
(
  input  data_t a,
  input  data_t b,
  output data_t p
);

  logic signed [PROD_WIDTH-1:0] full;
  logic signed [PROD_WIDTH-1:0] shifted;
  logic [PROD_WIDTH-DATA_WIDTH:0] upper;

  assign full    = PROD_WIDTH'(a) * PROD_WIDTH'(b);
  assign shifted = full >>> FRAC_BITS;
  assign upper   = shifted[PROD_WIDTH-1:DATA_WIDTH-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      p = shifted[DATA_WIDTH-1:0];
    end else begin
      p = shifted[PROD_WIDTH-1] ? DMIN : DMAX;
    end
  end

endmodule

// File: hdl/three_phase_capacitor_companion_top.sv
// ----------------------------------------------------------------------------
// three_phase_capacitor_companion_top
// Registered in the input, product and result stages from req accept to rsp_valid.
// Throughput: one item per cycle while rsp_stall does not hold the result; the history loop closes in the result stage.
// The result register lets a new item enter while a finished one waits.
// Reset (rst, synchronous): empties all stages, clears registers and history.
// ----------------------------------------------------------------------------
module three_phase_capacitor_companion_top
  import tpcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_reg_t cfg_index,
  input  data_t    cfg_data
);

  // configuration
  data_t cond_aa, cond_bb, cond_cc, cond_ab, cond_ac, cond_bc;
  logic  term0_grounded, term1_grounded;
  data_t gmat [PHASES][PHASES];

  // state
  data_t history [PHASES];

  // stage 1: branch voltage
  logic  valid1;
  logic  init1;
  data_t volt1 [PHASES];
  data_t curr1 [PHASES];
  data_t volt1_next [PHASES];

  // stage 2: products
  logic  valid2;
  logic  init2;
  data_t volt2 [PHASES];
  data_t curr2 [PHASES];
  data_t prod2 [PHASES][PHASES];
  data_t prod_next [PHASES][PHASES];

  // stage 3 logic
  data_t gv [PHASES];
  data_t curr_res [PHASES];
  data_t hist_res [PHASES];

  logic en1, en2, en3;
  data_t node0 [PHASES];
  data_t node1 [PHASES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cond_aa <= '0;
      cond_bb <= '0;
      cond_cc <= '0;
      cond_ab <= '0;
      cond_ac <= '0;
      cond_bc <= '0;
      term0_grounded <= 1'b0;
      term1_grounded <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COND_AA:   cond_aa <= cfg_data;
        REG_COND_BB:   cond_bb <= cfg_data;
        REG_COND_CC:   cond_cc <= cfg_data;
        REG_COND_AB:   cond_ab <= cfg_data;
        REG_COND_AC:   cond_ac <= cfg_data;
        REG_COND_BC:   cond_bc <= cfg_data;
        REG_TERM0_GND: term0_grounded <= cfg_data[0];
        REG_TERM1_GND: term1_grounded <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gmat[0][0] = cond_aa;
    gmat[1][1] = cond_bb;
    gmat[2][2] = cond_cc;
    gmat[0][1] = cond_ab;
    gmat[1][0] = cond_ab;
    gmat[0][2] = cond_ac;
    gmat[2][0] = cond_ac;
    gmat[1][2] = cond_bc;
    gmat[2][1] = cond_bc;
  end

  // flow control
  assign en3       = !rsp_valid || !rsp_stall;
  assign en2       = !valid2 || en3;
  assign en1       = !valid1 || en2;
  assign req_stall = !en1;

  // stage 1
  assign node0[0] = req.node0_a;
  assign node0[1] = req.node0_b;
  assign node0[2] = req.node0_c;
  assign node1[0] = req.node1_a;
  assign node1[1] = req.node1_b;
  assign node1[2] = req.node1_c;

  always_comb begin
    for (int k = 0; k < PHASES; k++) begin
      if (req.req_type == REQ_INIT) begin
        volt1_next[k] = node0[k];
      end else begin
        volt1_next[k] = sat_sub(term1_grounded ? '0 : node1[k],
                                term0_grounded ? '0 : node0[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en1) begin
      valid1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && req_valid) begin
      init1 <= (req.req_type == REQ_INIT);
      for (int k = 0; k < PHASES; k++) begin
        volt1[k] <= volt1_next[k];
        curr1[k] <= node1[k];
      end
    end
  end

  // stage 2
  for (genvar r = 0; r < PHASES; r++) begin : g_row
    for (genvar c = 0; c < PHASES; c++) begin : g_col
      tpcc_fxmul u_mul (
        .a (gmat[r][c]),
        .b (volt1[c]),
        .p (prod_next[r][c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (en2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && valid1) begin
      init2 <= init1;
      volt2 <= volt1;
      curr2 <= curr1;
      prod2 <= prod_next;
    end
  end

  // stage 3: sums, current and next history
  always_comb begin
    for (int r = 0; r < PHASES; r++) begin
      gv[r] = sat_add(sat_add(prod2[r][0], prod2[r][1]), prod2[r][2]);
      curr_res[r] = init2 ? curr2[r] : sat_add(gv[r], history[r]);
      hist_res[r] = sat_sub(sat_neg(curr_res[r]), gv[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      for (int k = 0; k < PHASES; k++) begin
        history[k] <= '0;
      end
    end else begin
      if (en3) begin
        rsp_valid <= valid2;
      end
      if (en3 && valid2) begin
        history <= hist_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && valid2) begin
      rsp.volt_a <= volt2[0];
      rsp.volt_b <= volt2[1];
      rsp.volt_c <= volt2[2];
      rsp.curr_a <= curr_res[0];
      rsp.curr_b <= curr_res[1];
      rsp.curr_c <= curr_res[2];
      rsp.hist_a <= hist_res[0];
      rsp.hist_b <= hist_res[1];
      rsp.hist_c <= hist_res[2];
    end
  end

  // checks
  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    !(en3 && valid2) |=> $stable(history[0]) && $stable(history[1]) && $stable(history[2]))
    else $error("history changed without an item leaving the product stage");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(valid2))
    else $error("result appeared with no item in the product stage");

  a_hist_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.hist_a == history[0]) && (rsp.hist_b == history[1])
                  && (rsp.hist_c == history[2]))
    else $error("stored history differs from reported history");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-phase capacitor companion block. Step
// and init items go in through a valid/stall channel and each result is
// compared field by field with a bit-exact Q16.16 predictor. The bench uses
// several conductance and grounding settings, random gaps on both sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tpcc_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     LATENCY      = 3;
  localparam int     PHASE_ITEMS  = 200;
  localparam int     PHASE_COUNT  = 7;
  localparam longint HI_LIM       = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint LO_LIM       = -HI_LIM - 1;
  localparam data_t  UNIT         = 32'sh0001_0000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  req_t     req;
  logic     rsp_valid;
  logic     rsp_stall;
  rsp_t     rsp;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_reg_t cfg_index;
  data_t    cfg_data;

  longint conductance [3][3];
  bit     ground0;
  bit     ground1;
  longint history [3];

  rsp_t  expected_rsps [$];
  int    errors = 0;
  int    cycles = 0;
  bit    send_gaps_on = 1'b1;
  bit    take_gaps_on = 1'b1;
  int    hold_request = 0;
  string field_names [9] = '{"volt_a", "volt_b", "volt_c", "curr_a", "curr_b",
                             "curr_c", "hist_a", "hist_b", "hist_c"};

  three_phase_capacitor_companion_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[three_phase_capacitor_companion_top] ERROR");
      $finish;
    end
  end

  function automatic longint clamp_data(longint x);
    if (x > HI_LIM) return HI_LIM;
    if (x < LO_LIM) return LO_LIM;
    return x;
  endfunction

  function automatic longint scaled_product(longint g, longint v);
    return clamp_data((g * v) >>> FRAC_BITS);
  endfunction

  function automatic rsp_t predict_result(req_t item);
    longint n0 [3];
    longint n1 [3];
    longint v [3];
    longint i [3];
    longint h [3];
    longint gv;
    rsp_t   r;
    n0[0] = item.node0_a;
    n0[1] = item.node0_b;
    n0[2] = item.node0_c;
    n1[0] = item.node1_a;
    n1[1] = item.node1_b;
    n1[2] = item.node1_c;
    for (int k = 0; k < 3; k++) begin
      if (item.req_type == REQ_INIT) begin
        v[k] = n0[k];
      end else begin
        v[k] = clamp_data((ground1 ? 0 : n1[k]) - (ground0 ? 0 : n0[k]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      gv = 0;
      for (int c = 0; c < 3; c++) begin
        gv = clamp_data(gv + scaled_product(conductance[k][c], v[c]));
      end
      if (item.req_type == REQ_INIT) begin
        i[k] = n1[k];
      end else begin
        i[k] = clamp_data(gv + history[k]);
      end
      h[k] = clamp_data(clamp_data(-i[k]) - gv);
      history[k] = h[k];
    end
    r.volt_a = data_t'(v[0]);
    r.volt_b = data_t'(v[1]);
    r.volt_c = data_t'(v[2]);
    r.curr_a = data_t'(i[0]);
    r.curr_b = data_t'(i[1]);
    r.curr_c = data_t'(i[2]);
    r.hist_a = data_t'(h[0]);
    r.hist_b = data_t'(h[1]);
    r.hist_c = data_t'(h[2]);
    return r;
  endfunction

  function automatic data_t rand_voltage();
    data_t r;
    case ($urandom_range(0, 9))
      0: r = DMAX;
      1: r = DMIN;
      2: r = '0;
      3, 4, 5: r = data_t'($urandom_range(0, 32'h0010_0000)) - data_t'(32'h0008_0000);
      default: r = data_t'($urandom);
    endcase
    return r;
  endfunction

  function automatic data_t rand_conductance();
    return data_t'($urandom_range(0, 32'h0008_0000)) - data_t'(32'h0004_0000);
  endfunction

  function automatic req_t rand_item(bit init_item);
    req_t r;
    r.req_type = init_item ? REQ_INIT : REQ_STEP;
    r.node0_a  = rand_voltage();
    r.node0_b  = rand_voltage();
    r.node0_c  = rand_voltage();
    r.node1_a  = rand_voltage();
    r.node1_b  = rand_voltage();
    r.node1_c  = rand_voltage();
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(req_t item);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    expected_rsps.insert(expected_rsps.size(), predict_result(item));
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t index, data_t value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      REG_COND_AA: conductance[0][0] = value;
      REG_COND_BB: conductance[1][1] = value;
      REG_COND_CC: conductance[2][2] = value;
      REG_COND_AB: begin
        conductance[0][1] = value;
        conductance[1][0] = value;
      end
      REG_COND_AC: begin
        conductance[0][2] = value;
        conductance[2][0] = value;
      end
      REG_COND_BC: begin
        conductance[1][2] = value;
        conductance[2][1] = value;
      end
      REG_TERM0_GND: ground0 = value[0];
      REG_TERM1_GND: ground1 = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_conductance(data_t aa, data_t bb, data_t cc, data_t ab, data_t ac,
                                 data_t bc, bit g0, bit g1);
    write_reg(REG_COND_AA, aa);
    write_reg(REG_COND_BB, bb);
    write_reg(REG_COND_CC, cc);
    write_reg(REG_COND_AB, ab);
    write_reg(REG_COND_AC, ac);
    write_reg(REG_COND_BC, bc);
    write_reg(REG_TERM0_GND, g0 ? data_t'(1) : data_t'(0));
    write_reg(REG_TERM1_GND, g1 ? data_t'(1) : data_t'(0));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic check_result(rsp_t got);
    rsp_t  want;
    data_t want_field;
    data_t got_field;
    if (expected_rsps.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = expected_rsps.pop_front();
    for (int k = 0; k < 9; k++) begin
      want_field = want[(8 - k) * DATA_WIDTH +: DATA_WIDTH];
      got_field  = got[(8 - k) * DATA_WIDTH +: DATA_WIDTH];
      if (want_field !== got_field) begin
        $display("%0t: %s expected %0d actual %0d", $time, field_names[k], want_field,
                 got_field);
        errors++;
      end
    end
  endtask

  // result side: random stall per item, or a long hold-off when requested
  initial begin : result_side
    int wait_cycles;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
      end else begin
        wait_cycles = take_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (wait_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      check_result(rsp);
      @(negedge clk);
    end
  end

  // registers and history are zero after reset
  task automatic test_reset_defaults();
    send_item('{REQ_STEP, DMIN, DMIN, DMIN, DMAX, DMAX, DMAX});
    send_item('{REQ_STEP, DMAX, UNIT, '0, DMIN, -UNIT, UNIT});
    wait_idle();
  endtask

  task automatic test_extremes();
    set_conductance(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0, 1'b0);
    send_item('{REQ_STEP, DMIN, DMIN, DMIN, DMAX, DMAX, DMAX});
    send_item('{REQ_STEP, DMAX, DMAX, DMAX, DMIN, DMIN, DMIN});
    send_item('{REQ_INIT, DMAX, DMIN, '0, DMIN, DMAX, '0});
    wait_idle();
    set_conductance(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, 1'b0, 1'b0);
    send_item('{REQ_STEP, DMIN, DMIN, DMIN, DMAX, DMAX, DMAX});
    send_item('{REQ_STEP, DMAX, DMAX, DMAX, DMIN, DMIN, DMIN});
    send_item('{REQ_INIT, DMIN, DMAX, UNIT, DMIN, DMIN, DMIN});
    wait_idle();
    set_conductance(2 * UNIT, 2 * UNIT, 2 * UNIT, UNIT / 2, UNIT / 2, -UNIT / 4, 1'b0, 1'b0);
    send_item('{REQ_INIT, UNIT, -2 * UNIT, 7 * UNIT / 2, UNIT / 4, -3 * UNIT / 4, '0});
    send_item('{REQ_STEP, UNIT, 32'sh0000_0001, -UNIT, 3 * UNIT, -32'sh0000_0001, UNIT});
    send_item('{REQ_STEP, -UNIT / 3, UNIT / 7, '0, UNIT / 5, -UNIT, 2 * UNIT});
    send_item('{REQ_STEP, '0, '0, '0, '0, '0, '0});
    wait_idle();
  endtask

  // single grounded terminals, then both grounded with the history at its minimum
  task automatic test_grounding();
    set_conductance(UNIT, UNIT, UNIT, '0, '0, '0, 1'b1, 1'b0);
    send_item('{REQ_STEP, DMAX, UNIT, -UNIT, UNIT, 2 * UNIT, 3 * UNIT});
    wait_idle();
    set_conductance(UNIT, UNIT, UNIT, '0, '0, '0, 1'b0, 1'b1);
    send_item('{REQ_STEP, UNIT, 2 * UNIT, 3 * UNIT, DMIN, UNIT, -UNIT});
    send_item('{REQ_INIT, UNIT, UNIT, UNIT, DMAX, DMAX, DMAX});
    wait_idle();
    set_conductance(UNIT, UNIT, UNIT, '0, '0, '0, 1'b1, 1'b1);
    send_item('{REQ_STEP, DMAX, DMIN, UNIT, DMIN, DMAX, -UNIT});
    send_item('{REQ_STEP, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT});
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1: set_conductance(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, $urandom_range(0, 1),
                           $urandom_range(0, 1));
        2: set_conductance(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, $urandom_range(0, 1),
                           $urandom_range(0, 1));
        3: set_conductance(data_t'($urandom), data_t'($urandom), data_t'($urandom),
                           data_t'($urandom), data_t'($urandom), data_t'($urandom),
                           1'b0, 1'b0);
        default: set_conductance(rand_conductance(), rand_conductance(), rand_conductance(),
                                 rand_conductance(), rand_conductance(), rand_conductance(),
                                 $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      send_item(rand_item(1'b1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          send_gaps_on = $urandom_range(0, 3) != 0;
          take_gaps_on = $urandom_range(0, 3) != 0;
        end
        send_item(rand_item($urandom_range(0, 11) == 0));
      end
      wait_idle();
    end
    send_gaps_on = 1'b1;
    take_gaps_on = 1'b1;
  endtask

  // receiver holds off while items keep coming back to back
  task automatic test_backpressure();
    set_conductance(rand_conductance(), rand_conductance(), rand_conductance(),
                    rand_conductance(), rand_conductance(), rand_conductance(), 1'b0, 1'b0);
    send_gaps_on = 1'b0;
    take_gaps_on = 1'b0;
    hold_request = 300;
    for (int n = 0; n < 60; n++) begin
      send_item(rand_item(n == 0));
    end
    wait_idle();
    send_gaps_on = 1'b1;
    take_gaps_on = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_COND_AA;
    cfg_data  = '0;
    for (int r = 0; r < 3; r++) begin
      history[r] = 0;
      for (int c = 0; c < 3; c++) begin
        conductance[r][c] = 0;
      end
    end
    ground0 = 1'b0;
    ground1 = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_extremes();
    test_grounding();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("[three_phase_capacitor_companion_top] OK");
    end else begin
      $display("[three_phase_capacitor_companion_top] ERROR");
    end
    $finish;
  end

endmodule
